[sv/hdf_pkg.sv]
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types, constants and helper functions of the fire field block.
// ----------------------------------------------------------------------------
package hdf_pkg;

    // Default geometry and heat range
    localparam int DEF_FIELD_WIDTH  = 128;
    localparam int DEF_FIELD_HEIGHT = 64;
    localparam int DEF_HEAT_MAX     = 63;
    localparam int DEF_SOURCE_DEPTH = 2;

    // Noise generator
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Configuration registers
    localparam logic [0:0] REG_COOLING = 1'd0;
    localparam logic [0:0] REG_FLICKER = 1'd1;
    localparam logic [3:0] COOLING_RESET = 4'd3;
    localparam logic [4:0] FLICKER_RESET = 5'd12;

    // Item kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // take input item, rewind counters
        logic clr_wr;      // clear one cell at the linear pointer
        logic seed_wr;     // seed one source cell
        logic ext_wr;      // extinguish one source cell
        logic lin_load;    // point the linear pointer at the source rows
        logic pre_issue;   // fetch the wrap neighbors of the row below
        logic strm_issue;  // fetch one column of the two rows below
        logic row_next;    // advance to the next row
        logic rd_issue;    // read one cell for a read item
        logic out_load;    // load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic kind;
        logic burn;
        logic lin_last;
        logic x_last;
        logic y_last;
        logic out_busy;
    } sts_t;

    // One Galois step of the noise register
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] t;
        begin
            t = s >> 1;
            if (s[0]) begin
                t = t ^ LFSR_TAPS;
            end
            return t;
        end
    endfunction

    // Heat to RGB565: black, red, yellow, white ramp
    function automatic logic [15:0] palette_rgb565(input logic [7:0] h);
        logic [7:0] stp;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        begin
            stp = 8'({4'd0, h[3:0]} * 8'd17);
            r = 8'd255;
            g = 8'd255;
            b = 8'd255;
            case (h[7:4])
                4'd0: begin
                    r = stp;
                    g = 8'd0;
                    b = 8'd0;
                end
                4'd1: begin
                    g = stp;
                    b = 8'd0;
                end
                4'd2: begin
                    b = stp;
                end
                default: begin
                    r = 8'd255;
                end
            endcase
            return {r[7:3], g[7:2], b[7:3]};
        end
    endfunction

endpackage

[sv/heat_diffusion_fire_frame.sv]
// ----------------------------------------------------------------------------
// heat_diffusion_fire_frame
// Fire field: heat map with frame steps and palette reads.
// ----------------------------------------------------------------------------
// Input channel s_*: kind 0 advances one frame (burn seeds or clears the
// source rows), kind 1 reads the cell at row/column. Each item yields exactly
// one transfer on the m_* channel: a frame step answers zeros, a read answers
// the cell heat and its RGB565 color (zero outside the field).
// Items are worked one at a time; the heat map is a memory with one write and
// two read ports, and the diffusion pass retires one cell per cycle within a
// row. A frame step seeds the source rows when burn is set, runs the
// diffusion pass, then extinguishes the source rows when burn is clear.
// A read fetches the cell from the heat map into the result register.
// The result register lets the next input transfer happen while a result
// waits; a stalled receiver holds the block only when the next result is
// ready to load. After reset all W*H heat map cells are cleared (8192 at
// the default size) before s_ready rises; cfg writes are taken at any time.
// ----------------------------------------------------------------------------
module heat_diffusion_fire_frame #(
    parameter int FIELD_WIDTH  = hdf_pkg::DEF_FIELD_WIDTH,
    parameter int FIELD_HEIGHT = hdf_pkg::DEF_FIELD_HEIGHT,
    parameter int HEAT_MAX     = hdf_pkg::DEF_HEAT_MAX,
    parameter int SOURCE_DEPTH = hdf_pkg::DEF_SOURCE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic        s_burn,
    input  logic [5:0]  s_row,
    input  logic [6:0]  s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_answered_kind,
    output logic [5:0]  m_heat_level,
    output logic [15:0] m_pixel_color
);

    logic [3:0]    cooling_reg;
    logic [4:0]    flicker_reg;
    hdf_pkg::cmd_t cmd;
    hdf_pkg::sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cooling_reg <= hdf_pkg::COOLING_RESET;
            flicker_reg <= hdf_pkg::FLICKER_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                hdf_pkg::REG_COOLING: cooling_reg <= cfg_wdata[3:0];
                hdf_pkg::REG_FLICKER: flicker_reg <= cfg_wdata;
                default: begin
                    cooling_reg <= cooling_reg;
                end
            endcase
        end
    end

    hdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hdf_dpath #(
        .FIELD_WIDTH  (FIELD_WIDTH),
        .FIELD_HEIGHT (FIELD_HEIGHT),
        .HEAT_MAX     (HEAT_MAX),
        .SOURCE_DEPTH (SOURCE_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cooling_limit   (cooling_reg),
        .flicker_span    (flicker_reg),
        .s_kind          (s_kind),
        .s_burn          (s_burn),
        .s_row           (s_row),
        .s_column        (s_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_answered_kind (m_answered_kind),
        .m_heat_level    (m_heat_level),
        .m_pixel_color   (m_pixel_color)
    );

endmodule

[sv/hdf_ctrl.sv]
// ----------------------------------------------------------------------------
// hdf_ctrl
// Sequencer: clearing pass, frame step phases, cell reads, result handoff.
// ----------------------------------------------------------------------------
module hdf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hdf_pkg::sts_t sts,
    output hdf_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_DISP  = 10'b0000000100,
        ST_SEED  = 10'b0000001000,
        ST_PRE   = 10'b0000010000,
        ST_DIFF  = 10'b0000100000,
        ST_TAIL  = 10'b0001000000,
        ST_EXT   = 10'b0010000000,
        ST_RD    = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.lin_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                if (sts.kind == hdf_pkg::KIND_READ) begin
                    state_next = ST_RD;
                end else if (sts.burn) begin
                    state_next = ST_SEED;
                end else begin
                    state_next = ST_PRE;
                end
            end
            ST_SEED: begin
                cmd.seed_wr = 1'b1;
                if (sts.lin_last) begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                cmd.pre_issue = 1'b1;
                state_next    = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.strm_issue = 1'b1;
                if (sts.x_last) begin
                    cmd.row_next = 1'b1;
                    state_next   = sts.y_last ? ST_TAIL : ST_PRE;
                end
            end
            ST_TAIL: begin
                // last cell of the diffusion pass retires here
                cmd.lin_load = 1'b1;
                state_next   = sts.burn ? ST_DONE : ST_EXT;
            end
            ST_EXT: begin
                cmd.ext_wr = 1'b1;
                if (sts.lin_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/hdf_dpath.sv]
// ----------------------------------------------------------------------------
// hdf_dpath
// Heat map memory, noise generator, diffusion arithmetic and result register.
// ----------------------------------------------------------------------------
module hdf_dpath #(
    parameter int FIELD_WIDTH  = hdf_pkg::DEF_FIELD_WIDTH,
    parameter int FIELD_HEIGHT = hdf_pkg::DEF_FIELD_HEIGHT,
    parameter int HEAT_MAX     = hdf_pkg::DEF_HEAT_MAX,
    parameter int SOURCE_DEPTH = hdf_pkg::DEF_SOURCE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  hdf_pkg::cmd_t cmd,
    output hdf_pkg::sts_t sts,
    input  logic [3:0]    cooling_limit,
    input  logic [4:0]    flicker_span,
    input  logic          s_kind,
    input  logic          s_burn,
    input  logic [5:0]    s_row,
    input  logic [6:0]    s_column,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_answered_kind,
    output logic [5:0]    m_heat_level,
    output logic [15:0]   m_pixel_color
);

    localparam int CELLS     = FIELD_WIDTH * FIELD_HEIGHT;
    localparam int AW        = $clog2(CELLS);
    localparam int XW        = $clog2(FIELD_WIDTH);
    localparam int YW        = $clog2(FIELD_HEIGHT);
    localparam int HW        = $clog2(HEAT_MAX + 1);
    localparam int SRC_FIRST = (FIELD_HEIGHT > SOURCE_DEPTH) ?
                               (FIELD_HEIGHT - SOURCE_DEPTH) : 0;
    localparam int SRC_BASE  = SRC_FIRST * FIELD_WIDTH;

    // Heat map
    logic [HW-1:0] mem [CELLS];
    logic [HW-1:0] rda_reg;
    logic [HW-1:0] rdb_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [HW-1:0] wr_data;
    logic          rda_en;
    logic          rdb_en;
    logic [AW-1:0] rda_addr;
    logic [AW-1:0] rdb_addr;

    // Item capture
    logic          kind_reg;
    logic          burn_reg;
    logic [5:0]    row_reg;
    logic [6:0]    col_reg;

    // Scan pointers
    logic [AW-1:0] lin_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [AW-1:0] base0_reg;
    logic [AW-1:0] base1_reg;
    logic [AW-1:0] base2_reg;
    logic          x_last;
    logic          y_last;
    logic [XW-1:0] xp1;

    // Diffusion pipeline
    logic          pre_v_reg;
    logic          proc_v_reg;
    logic [XW-1:0] px_reg;
    logic [AW-1:0] pbase_reg;
    logic [HW-1:0] left_reg;
    logic [HW-1:0] mid_reg;
    logic [HW+1:0] sum;
    logic [8:0]    avg9;
    logic [8:0]    cool9;
    logic [HW-1:0] diff_val;
    logic [XW-1:0] tx;

    // Noise
    logic [15:0]   lfsr_reg;
    logic [15:0]   s1;
    logic [15:0]   s2;
    logic [20:0]   cool_prod;
    logic [17:0]   drift_prod;
    logic [20:0]   flick_prod;
    logic [8:0]    flick9;
    logic [HW-1:0] seed_val;

    // Read item
    logic          in_range;
    logic [31:0]   rd_lin;
    logic [15:0]   heat_ext;

    // Result register
    logic          m_valid_reg;
    logic          kind_out_reg;
    logic [5:0]    heat_out_reg;
    logic [15:0]   color_out_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rda_en) begin
            rda_reg <= mem[rda_addr];
        end
        if (rdb_en) begin
            rdb_reg <= mem[rdb_addr];
        end
    end

    assign x_last = (x_reg == XW'(FIELD_WIDTH - 1));
    assign y_last = (y_reg == YW'(FIELD_HEIGHT - 2));
    assign xp1    = x_last ? '0 : x_reg + XW'(1);

    assign in_range = (32'(row_reg) < 32'(FIELD_HEIGHT)) &&
                      (32'(col_reg) < 32'(FIELD_WIDTH));
    assign rd_lin   = 32'(row_reg) * 32'(FIELD_WIDTH) + 32'(col_reg);

    // Read ports: wrap prefetch, column stream, or a single cell
    always_comb begin
        rda_en   = cmd.pre_issue || cmd.strm_issue || cmd.rd_issue;
        rdb_en   = cmd.pre_issue || cmd.strm_issue;
        rda_addr = base1_reg + AW'(xp1);
        rdb_addr = base2_reg + AW'(x_reg);
        if (cmd.pre_issue) begin
            rda_addr = base1_reg + AW'(FIELD_WIDTH - 1);
            rdb_addr = base1_reg;
        end else if (cmd.rd_issue) begin
            rda_addr = rd_lin[AW-1:0];
        end
    end

    // Noise draws
    assign s1         = hdf_pkg::lfsr_step(lfsr_reg);
    assign s2         = hdf_pkg::lfsr_step(s1);
    assign cool_prod  = 21'(s1) * 21'({1'b0, cooling_limit} + 5'd1);
    assign drift_prod = 18'(s2) * 18'd3;
    assign flick_prod = 21'(s1) * 21'(flicker_span);
    assign flick9     = 9'(flick_prod[20:16]);
    assign seed_val   = (flick9 < 9'(HEAT_MAX)) ? HW'(9'(HEAT_MAX) - flick9) : '0;

    // Average of three below plus two below, minus cooling
    assign sum      = (HW+2)'(left_reg) + (HW+2)'(mid_reg) +
                      (HW+2)'(rda_reg) + (HW+2)'(rdb_reg);
    assign avg9     = 9'(sum[HW+1:2]);
    assign cool9    = 9'(cool_prod[20:16]);
    assign diff_val = (avg9 > cool9) ? HW'(avg9 - cool9) : '0;

    always_comb begin
        case (drift_prod[17:16])
            2'd0:    tx = (px_reg == '0) ? XW'(FIELD_WIDTH - 1) : px_reg - XW'(1);
            2'd1:    tx = px_reg;
            default: tx = (px_reg == XW'(FIELD_WIDTH - 1)) ? '0 : px_reg + XW'(1);
        endcase
    end

    always_comb begin
        wr_en   = proc_v_reg || cmd.seed_wr || cmd.clr_wr || cmd.ext_wr;
        wr_addr = lin_reg;
        wr_data = '0;
        if (proc_v_reg) begin
            wr_addr = pbase_reg + AW'(tx);
            wr_data = diff_val;
        end else if (cmd.seed_wr) begin
            wr_data = seed_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg   <= hdf_pkg::LFSR_SEED;
            lin_reg    <= '0;
            pre_v_reg  <= 1'b0;
            proc_v_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
        end else begin
            pre_v_reg  <= cmd.pre_issue;
            proc_v_reg <= cmd.strm_issue;
            if (proc_v_reg) begin
                lfsr_reg <= s2;
            end else if (cmd.seed_wr) begin
                lfsr_reg <= s1;
            end
            if (cmd.capture || cmd.lin_load) begin
                lin_reg <= AW'(SRC_BASE);
            end else if (cmd.clr_wr || cmd.seed_wr || cmd.ext_wr) begin
                lin_reg <= lin_reg + AW'(1);
            end
            if (cmd.capture) begin
                x_reg <= '0;
                y_reg <= '0;
            end else if (cmd.row_next) begin
                x_reg <= '0;
                y_reg <= y_reg + YW'(1);
            end else if (cmd.strm_issue) begin
                x_reg <= xp1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            burn_reg  <= s_burn;
            row_reg   <= s_row;
            col_reg   <= s_column;
            base0_reg <= '0;
            base1_reg <= AW'(FIELD_WIDTH);
            base2_reg <= AW'(2 * FIELD_WIDTH);
        end else if (cmd.row_next) begin
            base0_reg <= base0_reg + AW'(FIELD_WIDTH);
            base1_reg <= base1_reg + AW'(FIELD_WIDTH);
            // two-below row sticks at the bottom
            if (32'(y_reg) + 32'd3 < 32'(FIELD_HEIGHT)) begin
                base2_reg <= base2_reg + AW'(FIELD_WIDTH);
            end
        end
        if (cmd.strm_issue) begin
            px_reg    <= x_reg;
            pbase_reg <= base0_reg;
        end
        if (pre_v_reg) begin
            left_reg <= rda_reg;
            mid_reg  <= rdb_reg;
        end else if (proc_v_reg) begin
            left_reg <= mid_reg;
            mid_reg  <= rda_reg;
        end
    end

    // Result register
    assign heat_ext = 16'(rda_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            kind_out_reg <= kind_reg;
            if (kind_reg == hdf_pkg::KIND_READ && in_range) begin
                heat_out_reg  <= heat_ext[5:0];
                color_out_reg <= hdf_pkg::palette_rgb565(heat_ext[7:0]);
            end else begin
                heat_out_reg  <= '0;
                color_out_reg <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_answered_kind = kind_out_reg;
    assign m_heat_level    = heat_out_reg;
    assign m_pixel_color   = color_out_reg;

    assign sts.kind     = kind_reg;
    assign sts.burn     = burn_reg;
    assign sts.lin_last = (lin_reg == AW'(CELLS - 1));
    assign sts.x_last   = x_last;
    assign sts.y_last   = y_last;
    assign sts.out_busy = m_valid_reg && !m_ready;

    // Prefetch capture and cell retirement never share a cycle
    a_window_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pre_v_reg && proc_v_reg))
        else $error("window prefetch collides with cell retirement");

    // Only one writer drives the heat map at a time
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({proc_v_reg, cmd.seed_wr, cmd.clr_wr, cmd.ext_wr}))
        else $error("more than one heat map writer");

    // A loaded result is presented on the next cycle
    a_out_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

    // Result register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("pending result overwritten");

endmodule

[bench/tb_heat_diffusion_fire_frame.sv]
// ----------------------------------------------------------------------------
// tb_heat_diffusion_fire_frame
// Self-checking bench for the fire field: frame steps and cell reads.
// ----------------------------------------------------------------------------
// A directed table goes first, then random phases that each start with a new
// cooling / flicker setting. Every input transfer runs a local copy of the
// heat map and noise register, and every result is checked against the
// oldest queued expectation. Both sides idle at random outside one calm
// phase. One long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_heat_diffusion_fire_frame;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = hdf_pkg::DEF_FIELD_WIDTH;
    localparam int FH = hdf_pkg::DEF_FIELD_HEIGHT;
    localparam int HMAX = hdf_pkg::DEF_HEAT_MAX;
    localparam int SRC_ROW = (FH > hdf_pkg::DEF_SOURCE_DEPTH) ?
                             FH - hdf_pkg::DEF_SOURCE_DEPTH : 0;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic       kind;
        logic       burn;
        logic [5:0] row;
        logic [6:0] column;
        bit         typed;
        logic [5:0] heat;
        logic [15:0] color;
    } item_t;

    typedef struct {
        logic        kind;
        logic [5:0]  heat;
        logic [15:0] color;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = hdf_pkg::REG_COOLING;
    logic [4:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = hdf_pkg::KIND_READ;
    logic        s_burn = 1'b0;
    logic [5:0]  s_row = '0;
    logic [6:0]  s_column = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_answered_kind;
    logic [5:0]  m_heat_level;
    logic [15:0] m_pixel_color;

    heat_diffusion_fire_frame dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_burn(s_burn),
        .s_row(s_row), .s_column(s_column),
        .m_valid(m_valid), .m_ready(m_ready), .m_answered_kind(m_answered_kind),
        .m_heat_level(m_heat_level), .m_pixel_color(m_pixel_color)
    );

    always #5 aclk = ~aclk;

    // local copy of the block state
    logic [7:0]  heat_copy [FW*FH];
    logic [15:0] noise;
    logic [3:0]  cool_lim;
    logic [4:0]  flick_span;

    item_t   item_q[$];
    item_t   cur_item;
    answer_t answer_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      sent = 0;
    int      taken = 0;
    bit      calm = 1'b0;     // no idling on either side
    bit      hold_req = 1'b0;

    function automatic int unsigned noise_draw(int unsigned n);
        noise = hdf_pkg::lfsr_step(noise);
        return (int'(noise) * n) >> 16;
    endfunction

    function automatic logic [15:0] heat_to_rgb(int unsigned h);
        int unsigned seg, stp, r, g, b;
        seg = h / 16;
        stp = (h % 16) * 17;
        r = 255; g = 255; b = 255;
        if (seg == 0) begin r = stp; g = 0; b = 0; end
        else if (seg == 1) begin g = stp; b = 0; end
        else if (seg == 2) begin b = stp; end
        return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
    endfunction

    function automatic void advance_frame(bit burning);
        int unsigned f, y, x, lt, rt, b2, sum, v, cl, d, tx;
        if (burning) begin
            for (y = SRC_ROW; y < FH; y++)
                for (x = 0; x < FW; x++) begin
                    f = noise_draw(flick_span);
                    heat_copy[y*FW + x] = (f < HMAX) ? 8'(HMAX - f) : 8'd0;
                end
        end
        for (y = 0; y + 1 < FH; y++) begin
            b2 = (y + 2 < FH) ? y + 2 : FH - 1;
            for (x = 0; x < FW; x++) begin
                lt = (x == 0) ? FW - 1 : x - 1;
                rt = (x == FW - 1) ? 0 : x + 1;
                sum = heat_copy[(y+1)*FW + lt] + heat_copy[(y+1)*FW + x]
                    + heat_copy[(y+1)*FW + rt] + heat_copy[b2*FW + x];
                v = sum / 4;
                cl = noise_draw(cool_lim + 1);
                d = noise_draw(3);
                v = (v > cl) ? v - cl : 0;
                tx = (d == 0) ? lt : (d == 1) ? x : rt;
                heat_copy[y*FW + tx] = 8'(v);
            end
        end
        if (!burning) begin
            for (y = SRC_ROW; y < FH; y++)
                for (x = 0; x < FW; x++) heat_copy[y*FW + x] = 8'd0;
        end
    endfunction

    function automatic answer_t predict_answer(item_t it);
        answer_t a;
        int unsigned h;
        a.kind = it.kind;
        a.heat = '0;
        a.color = '0;
        if (it.kind == hdf_pkg::KIND_FRAME) begin
            advance_frame(it.burn);
        end else if (it.row < FH && it.column < FW) begin
            h = heat_copy[it.row*FW + it.column];
            a.heat = 6'(h);
            a.color = heat_to_rgb(h);
        end
        return a;
    endfunction

    // input transfers feed the predictor, output transfers are checked
    always @(posedge aclk) begin
        answer_t a, e;
        cycles <= cycles + 1;
        if (s_valid && s_ready) begin
            a = predict_answer(cur_item);
            if (cur_item.typed) begin
                a.kind = cur_item.kind;
                a.heat = cur_item.heat;
                a.color = cur_item.color;
            end
            answer_q.push_back(a);
            taken <= taken + 1;
        end
        if (m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("unexpected result kind=%0d heat=%0d color=%h",
                             m_answered_kind, m_heat_level, m_pixel_color);
            end else begin
                e = answer_q.pop_front();
                if (e.kind !== m_answered_kind || e.heat !== m_heat_level ||
                    e.color !== m_pixel_color) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp kind=%0d heat=%0d color=%h, got %0d %0d %h",
                                 e.kind, e.heat, e.color,
                                 m_answered_kind, m_heat_level, m_pixel_color);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_heat_diffusion_fire_frame: errors");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(negedge aclk);
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
        end
    end

    task automatic add_row(logic k, logic b, int r, int c, bit t = 0,
                           int h = 0, int col = 0);
        item_t it;
        it.kind = k; it.burn = b; it.row = 6'(r); it.column = 7'(c);
        it.typed = t; it.heat = 6'(h); it.color = 16'(col);
        item_q.push_back(it);
    endtask

    task automatic send_items();
        int gap;
        while (item_q.size() > 0) begin
            if (!calm && $urandom_range(99) < 22) begin
                s_valid <= 1'b0;
                for (gap = $urandom_range(6, 1); gap > 0; gap--) @(negedge aclk);
            end
            cur_item = item_q.pop_front();
            s_kind <= cur_item.kind;
            s_burn <= cur_item.burn;
            s_row <= cur_item.row;
            s_column <= cur_item.column;
            s_valid <= 1'b1;
            do @(posedge aclk); while (!s_ready);
            sent++;
            @(negedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (taken != sent || answer_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [4:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == hdf_pkg::REG_COOLING) cool_lim = val[3:0];
        else flick_span = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int i, r;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 20) begin
                add_row(hdf_pkg::KIND_FRAME, $urandom_range(99) < 75,
                        $urandom_range(63), $urandom_range(127));
            end else begin
                r = ($urandom_range(1)) ? $urandom_range(63, 40) : $urandom_range(63);
                add_row(hdf_pkg::KIND_READ, $urandom_range(1), r, $urandom_range(127));
            end
        end
        send_items();
        drain();
    endtask

    initial begin
        int ph;
        for (int i = 0; i < FW*FH; i++) heat_copy[i] = 8'd0;
        noise = hdf_pkg::LFSR_SEED;
        cool_lim = hdf_pkg::COOLING_RESET;
        flick_span = hdf_pkg::FLICKER_RESET;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: cleared map, seeding, extinguishing
        add_row(hdf_pkg::KIND_READ, 0, 0, 0, 1, 0, 0);
        add_row(hdf_pkg::KIND_READ, 1, 63, 127, 1, 0, 0);
        add_row(hdf_pkg::KIND_FRAME, 1, 0, 0, 1, 0, 0);
        add_row(hdf_pkg::KIND_READ, 0, 63, 0);
        add_row(hdf_pkg::KIND_READ, 0, 62, 127);
        add_row(hdf_pkg::KIND_READ, 0, 61, 64);
        add_row(hdf_pkg::KIND_READ, 0, 0, 0);
        add_row(hdf_pkg::KIND_FRAME, 0, 63, 127, 1, 0, 0);
        add_row(hdf_pkg::KIND_READ, 0, 63, 5, 1, 0, 0);
        add_row(hdf_pkg::KIND_READ, 1, 62, 100, 1, 0, 0);
        add_row(hdf_pkg::KIND_FRAME, 1, 0, 0);
        add_row(hdf_pkg::KIND_FRAME, 1, 21, 42);
        add_row(hdf_pkg::KIND_FRAME, 1, 42, 85);
        add_row(hdf_pkg::KIND_READ, 0, 60, 3);
        add_row(hdf_pkg::KIND_READ, 1, 55, 77);
        add_row(hdf_pkg::KIND_READ, 0, 40, 21);
        add_row(hdf_pkg::KIND_READ, 1, 63, 127);
        send_items();
        drain();

        // settings: extremes, zero flicker span, span beyond the nominal range
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_cfg(hdf_pkg::REG_COOLING, 5'd0);
                    write_cfg(hdf_pkg::REG_FLICKER, 5'd1);
                end
                1: begin
                    write_cfg(hdf_pkg::REG_COOLING, 5'd15);
                    write_cfg(hdf_pkg::REG_FLICKER, 5'd16);
                end
                2: begin
                    write_cfg(hdf_pkg::REG_COOLING, 5'd1);
                    write_cfg(hdf_pkg::REG_FLICKER, 5'd0);
                end
                3: begin
                    write_cfg(hdf_pkg::REG_COOLING, 5'd2);
                    write_cfg(hdf_pkg::REG_FLICKER, 5'd31);
                end
                default: begin
                    write_cfg(hdf_pkg::REG_COOLING, 5'($urandom_range(15)));
                    write_cfg(hdf_pkg::REG_FLICKER, 5'($urandom_range(16, 1)));
                end
            endcase
            calm = (ph == 2);
            if (ph == 1) hold_req = 1'b1;
            random_phase(18);
            calm = 1'b0;
        end

        drain();
        if (answer_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("tb_heat_diffusion_fire_frame: clean");
        end else begin
            $display("tb_heat_diffusion_fire_frame: errors");
        end
        $finish;
    end
endmodule
